// ----- sv/pba_pkg.sv -----
// pba_pkg: constants, command codes and bit-search helpers for the page bitmap allocator
// no dependencies; imported by page_bitmap_allocator
package pba_pkg;

    localparam int PAGE_COUNT_DEF = 65536;
    localparam int WORD_W         = 64;
    localparam int BIT_W          = 6;
    localparam int MEM_MB_W       = 13;
    localparam logic [MEM_MB_W-1:0] MEM_MB_RST = 13'd256;

    // page counts from a 32 bit byte count fit in 21 bits
    localparam int NEED_W        = 21;
    localparam int PAGE_SHIFT    = 12;
    localparam int MB_PAGE_SHIFT = 8;
    // low reserved area plus gap, in pages
    localparam int RSV_PAGES     = (32'h400000 + 32'h10000) >> PAGE_SHIFT;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_CHECK = 2'd3;

    function automatic logic [BIT_W-1:0] lsb_idx(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (x[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] msb_idx(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    // bit j set when bits j-n+1 .. j of f are all set, n in 1..64
    function automatic logic [WORD_W-1:0] run_mask(input logic [WORD_W-1:0] f,
                                                   input logic [BIT_W:0] n);
        logic [WORD_W-1:0] x;
        logic [BIT_W:0]    len;
        x   = f;
        len = (BIT_W+1)'(1);
        for (int k = 0; k < BIT_W; k++) begin
            if (n >= (len << 1)) begin
                x   = x & (x << len);
                len = len << 1;
            end
        end
        x = x & (x << (n - len));
        return x;
    endfunction

endpackage

// ----- sv/pba_ram.sv -----
// pba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; holds the page bitmap words
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/page_bitmap_allocator.sv -----
// page_bitmap_allocator: busy bitmap of 4 KB pages, 64 pages per ram word, one word per cycle
// operations: init sweeps every word, allocate searches first-fit and then marks the run it found,
//   free clears its page range and check reads one word; zero-page allocate or free and out-of-range
//   requests skip the ram; the ram holds WORDS = PAGE_COUNT/64 words, rounded up (1024 by default)
// throughput: one request at a time; a request is taken only in the idle state
// reset: synchronous, marks every page busy in a sweep of the whole bitmap; no request is taken
//   during the sweep, configuration writes are; mem_mb resets to 256
// depends on pba_pkg and pba_ram
module page_bitmap_allocator #(
    parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // byte_count[31:0], page_number[47:32]
    input  logic [pba_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // cmd[1:0]
    input  logic [pba_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // ok[0], start_page[16:1], page_free[17], zero[23:18]
    output logic [pba_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pba_pkg::MEM_MB_W-1:0]    i_cfg_data
);

    import pba_pkg::*;

    localparam int WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = AW + BIT_W;
    localparam int CW    = IW + 1;
    localparam logic [AW-1:0]     LAST_W = AW'(WORDS - 1);
    localparam logic [NEED_W-1:0] PC_N   = NEED_W'(PAGE_COUNT);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INIT    = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_MARK_RD = 3'd3;
    localparam logic [2:0] S_MARK    = 3'd4;
    localparam logic [2:0] S_CHECK   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]          r_state, n_state;
    logic                r_fill, n_fill;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CW-1:0]       r_limit, n_limit;
    logic                r_out_valid, n_out_valid;
    logic [MEM_MB_W-1:0] r_mem_mb;

    logic [CW-1:0]       r_need, n_need;
    logic [CW-1:0]       r_run, n_run;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic                r_set, n_set;
    logic                r_res_ok, n_res_ok;
    logic [15:0]         r_res_start, n_res_start;
    logic                r_res_free, n_res_free;
    logic                r_out_ok, n_out_ok;
    logic [15:0]         r_out_start, n_out_start;
    logic                r_out_free, n_out_free;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                s_fire;
    logic [1:0]          in_cmd;
    logic [31:0]         in_bytes;
    logic [15:0]         in_page;
    logic [32:0]         bsum;
    logic [NEED_W-1:0]   in_need;
    logic [NEED_W-1:0]   pg_c;
    logic                page_ok;
    logic [NEED_W-1:0]   free_end;
    logic [NEED_W-1:0]   mb_pages;
    logic [NEED_W-1:0]   lim;

    logic [WORD_W-1:0]   busy;
    logic [BIT_W:0]      lead;
    logic [NEED_W-1:0]   span_sum;
    logic                span_hit;
    logic [CW-1:0]       span_d;
    logic                small_need;
    logic [WORD_W-1:0]   imask;
    logic                hit;
    logic [BIT_W-1:0]    p_hit;
    logic [CW-1:0]       hit_end;
    logic [CW-1:0]       hit_start;
    logic [CW-1:0]       run_next;

    logic [AW:0]         lim_w;
    logic [WORD_W-1:0]   init_word;
    logic [BIT_W-1:0]    lo_b, hi_b;
    logic [WORD_W-1:0]   mark_mask;
    logic                out_room;

    assign s_fire      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_cmd      = i_s_tuser;
    assign in_bytes    = i_s_tdata[31:0];
    assign in_page     = i_s_tdata[47:32];

    // request decode
    always_comb begin
        bsum     = {1'b0, in_bytes} + 33'd4095;
        in_need  = bsum[32:PAGE_SHIFT];
        pg_c     = NEED_W'(in_page);
        page_ok  = pg_c < PC_N;
        free_end = pg_c + in_need - NEED_W'(1);
        mb_pages = NEED_W'(r_mem_mb) << MB_PAGE_SHIFT;
        lim      = (mb_pages > NEED_W'(RSV_PAGES)) ? mb_pages - NEED_W'(RSV_PAGES) : '0;
        if (lim > PC_N) lim = PC_N;
    end

    // first-fit evaluation of the word that arrives from the ram
    always_comb begin
        busy       = ram_rdata;
        lead       = (busy == '0) ? (BIT_W+1)'(WORD_W) : {1'b0, lsb_idx(busy)};
        span_sum   = NEED_W'(r_run) + NEED_W'(lead);
        span_hit   = span_sum >= NEED_W'(r_need);
        span_d     = r_need - r_run - CW'(1);
        small_need = r_need <= CW'(WORD_W);
        imask      = small_need ? run_mask(~busy, (BIT_W+1)'(r_need)) : '0;
        hit        = span_hit || (imask != '0);
        p_hit      = span_hit ? span_d[BIT_W-1:0] : lsb_idx(imask);
        hit_end    = CW'({r_addr, p_hit});
        hit_start  = hit_end + CW'(1) - r_need;
        // free pages at the top of the word carry into the next one
        run_next   = (busy == '0) ? r_run + CW'(WORD_W)
                                  : CW'(BIT_W'(WORD_W - 1) - msb_idx(busy));
    end

    // init sweep word and range mask for marking or freeing
    always_comb begin
        lim_w = r_limit[CW-1:BIT_W];
        if (lim_w > {1'b0, r_addr}) begin
            init_word = '0;
        end else if (lim_w == {1'b0, r_addr}) begin
            init_word = {WORD_W{1'b1}} << r_limit[BIT_W-1:0];
        end else begin
            init_word = {WORD_W{1'b1}};
        end
        lo_b      = (r_addr == r_lo[IW-1:BIT_W]) ? r_lo[BIT_W-1:0] : '0;
        hi_b      = (r_addr == r_hi[IW-1:BIT_W]) ? r_hi[BIT_W-1:0] : BIT_W'(WORD_W - 1);
        mark_mask = ({WORD_W{1'b1}} << lo_b) &
                    ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_b));
    end

    assign out_room = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_limit     = r_limit;
        n_need      = r_need;
        n_run       = r_run;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_res_ok    = r_res_ok;
        n_res_start = r_res_start;
        n_res_free  = r_res_free;
        n_out_ok    = r_out_ok;
        n_out_start = r_out_start;
        n_out_free  = r_out_free;
        n_out_valid = r_out_valid && !i_m_tready;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = init_word;
        ram_raddr   = r_addr;

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_res_ok    = 1'b0;
                    n_res_start = '0;
                    n_res_free  = 1'b0;
                    n_state     = S_DONE;
                    case (in_cmd)
                        CMD_INIT: begin
                            n_limit = CW'(lim);
                            n_addr  = '0;
                            n_state = S_INIT;
                        end
                        CMD_ALLOC: begin
                            if (in_need == '0) begin
                                n_res_ok = 1'b1;
                            end else if (in_need <= PC_N) begin
                                n_need    = CW'(in_need);
                                n_run     = '0;
                                n_addr    = '0;
                                ram_raddr = '0;
                                n_state   = S_SEARCH;
                            end
                        end
                        CMD_FREE: begin
                            n_res_ok = 1'b1;
                            if (in_need != '0 && page_ok) begin
                                n_lo    = CW'(pg_c);
                                n_hi    = (free_end >= PC_N) ? CW'(PC_N - NEED_W'(1))
                                                             : CW'(free_end);
                                n_set   = 1'b0;
                                n_state = S_MARK_RD;
                            end
                        end
                        default: begin
                            if (page_ok) begin
                                ram_raddr = pg_c[IW-1:BIT_W];
                                n_lo      = CW'(pg_c);
                                n_state   = S_CHECK;
                            end
                        end
                    endcase
                end
            end
            S_INIT: begin
                ram_we = 1'b1;
                if (r_addr == LAST_W) begin
                    n_fill   = 1'b0;
                    n_res_ok = 1'b1;
                    n_state  = r_fill ? S_IDLE : S_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_SEARCH: begin
                if (r_addr != LAST_W) begin
                    ram_raddr = r_addr + AW'(1);
                end
                n_addr = r_addr + AW'(1);
                if (hit) begin
                    n_lo        = hit_start;
                    n_hi        = hit_end;
                    n_set       = 1'b1;
                    n_res_ok    = 1'b1;
                    n_res_start = 16'(hit_start);
                    n_state     = S_MARK_RD;
                end else if (r_addr == LAST_W) begin
                    n_state = S_DONE;
                end else begin
                    n_run = run_next;
                end
            end
            S_MARK_RD: begin
                ram_raddr = r_lo[IW-1:BIT_W];
                n_addr    = r_lo[IW-1:BIT_W];
                n_state   = S_MARK;
            end
            S_MARK: begin
                // write back word r_addr while the next one is read
                ram_we    = 1'b1;
                ram_wdata = r_set ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
                if (r_addr == r_hi[IW-1:BIT_W]) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                end
            end
            S_CHECK: begin
                n_res_ok   = 1'b1;
                n_res_free = !ram_rdata[r_lo[BIT_W-1:0]];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_room) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_start = r_res_start;
                    n_out_free  = r_res_free;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_fill      <= 1'b1;
            r_addr      <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
            r_mem_mb    <= MEM_MB_RST;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mem_mb <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need      <= n_need;
        r_run       <= n_run;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_set       <= n_set;
        r_res_ok    <= n_res_ok;
        r_res_start <= n_res_start;
        r_res_free  <= n_res_free;
        r_out_ok    <= n_out_ok;
        r_out_start <= n_out_start;
        r_out_free  <= n_out_free;
    end

    pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - 18){1'b0}}, r_out_free, r_out_start, r_out_ok};

    // a run carried into the next word is always shorter than the request
    a_run_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_run < r_need))
        else $error("search run reached request length without a hit");

    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK_RD || r_state == S_MARK) |->
        (r_lo <= r_hi && r_hi < CW'(PAGE_COUNT)))
        else $error("mark range out of order or past the map");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INIT || r_state == S_MARK))
        else $error("bitmap written outside init or mark");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state != S_IDLE))
        else $error("request transfer did not start an operation");

endmodule
